// ----- design/crb_pkg.sv -----
package crb_pkg;

  // datapath widths
  localparam int unsigned GUARD_BITS = 16;
  localparam int unsigned ANG_FRAC   = 24;
  localparam int unsigned XW         = 52;   // cordic x/y, q.16 (16 guard bits), signed
  localparam int unsigned ZW         = 35;   // angle accumulator, degrees q.24, signed
  localparam int unsigned ZUW        = 33;   // wrapped angle in [0, 360) degrees q.24
  localparam int unsigned MAX_CELLS  = 32;

  localparam logic [31:0]          GAIN_Q32  = 32'd2608131496;
  localparam logic signed [ZW-1:0] DEG180    = ZW'(64'sd180 <<< ANG_FRAC);
  localparam logic signed [ZW-1:0] DEG360    = ZW'(64'sd360 <<< ANG_FRAC);
  localparam logic [25:0]          HEAD_FULL = 26'(64'd360 << 16);
  localparam logic [32:0]          DIST_MAX  = {33{1'b1}};

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
  } in_word_t;

  typedef struct packed {
    logic [32:0] distance;
    logic [24:0] heading;
  } out_word_t;

  // word handed from cell to cell
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 same;   // start and target coincide
  } vec_t;

  // atan(2^-i) in degrees, q.24, rounded
  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:    a = 30'd754974720;
      5'd1:    a = 30'd445687602;
      5'd2:    a = 30'd235489088;
      5'd3:    a = 30'd119537938;
      5'd4:    a = 30'd60000934;
      5'd5:    a = 30'd30029717;
      5'd6:    a = 30'd15018523;
      5'd7:    a = 30'd7509719;
      5'd8:    a = 30'd3754917;
      5'd9:    a = 30'd1877466;
      5'd10:   a = 30'd938734;
      5'd11:   a = 30'd469367;
      5'd12:   a = 30'd234684;
      5'd13:   a = 30'd117342;
      5'd14:   a = 30'd58671;
      5'd15:   a = 30'd29335;
      5'd16:   a = 30'd14668;
      5'd17:   a = 30'd7334;
      5'd18:   a = 30'd3667;
      5'd19:   a = 30'd1833;
      5'd20:   a = 30'd917;
      5'd21:   a = 30'd458;
      5'd22:   a = 30'd229;
      5'd23:   a = 30'd115;
      5'd24:   a = 30'd57;
      5'd25:   a = 30'd29;
      5'd26:   a = 30'd14;
      5'd27:   a = 30'd7;
      5'd28:   a = 30'd4;
      5'd29:   a = 30'd2;
      5'd30:   a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/compass_range_and_bearing.sv -----
// channel | direction | word                          | handshake
// in_     | input     | from_x, from_y, to_x, to_y    | in_valid / in_stall
// out_    | output    | distance, heading             | out_valid / out_stall
//
// fully pipelined: one word accepted per cycle while in_stall is low, through
// one prep stage, one cell per cordic stage capped at 32, and three output stages
// for the two gain partial products and the final rounding
// rst_n is synchronous and clears only the valid bits; data registers hold junk
// every stage has its own valid and fills bubbles, so a stalled output word
// holds the tail of the pipe while upstream stages keep accepting as long as bubbles remain
module compass_range_and_bearing #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crb_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output crb_pkg::out_word_t out_word
);

  // only the tabled stages are built
  localparam int unsigned N_CELLS =
    (CORDIC_STAGES > crb_pkg::MAX_CELLS) ? crb_pkg::MAX_CELLS : CORDIC_STAGES;

  // chain links: index k feeds cell k, index N_CELLS feeds the output stages
  logic          vld_w  [N_CELLS+1];
  crb_pkg::vec_t vec_w  [N_CELLS+1];
  logic          free_w [N_CELLS+1];
  logic          prep_free;

  // differences, zero check and half-plane pre-rotation
  crb_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .free_dn   (free_w[0]),
    .out_valid (vld_w[0]),
    .out_vec   (vec_w[0]),
    .free_up   (prep_free)
  );

  assign in_stall = !prep_free;

  // row of vectoring cells, cell k shifts by k and adds or subtracts atan(2^-k)
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    crb_cell #(
      .STAGE (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_w[k]),
      .in_vec    (vec_w[k]),
      .free_dn   (free_w[k+1]),
      .out_valid (vld_w[k+1]),
      .out_vec   (vec_w[k+1]),
      .free_up   (free_w[k])
    );
  end

  // gain correction, degree wrap and rounding, output register
  crb_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_w[N_CELLS]),
    .in_vec    (vec_w[N_CELLS]),
    .free_up   (free_w[N_CELLS]),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

endmodule

// ----- design/crb_prep.sv -----
module crb_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  crb_pkg::in_word_t in_word,
  input  logic             free_dn,
  output logic             out_valid,
  output crb_pkg::vec_t    out_vec,
  output logic             free_up
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] ndx;
  logic signed [32:0] ndy;
  crb_pkg::vec_t      vec_nxt;
  crb_pkg::vec_t      vec_r;
  logic               valid_r;

  // both signs of the difference in parallel, pick one after
  always_comb begin
    dx  = 33'(in_word.to_x)   - 33'(in_word.from_x);
    dy  = 33'(in_word.to_y)   - 33'(in_word.from_y);
    ndx = 33'(in_word.from_x) - 33'(in_word.to_x);
    ndy = 33'(in_word.from_y) - 33'(in_word.to_y);
    vec_nxt.same = (dx == 33'sd0) && (dy == 33'sd0);
    if (dy < 33'sd0) begin
      vec_nxt.x = {{(crb_pkg::XW - 33 - crb_pkg::GUARD_BITS){ndy[32]}}, ndy,
                   {crb_pkg::GUARD_BITS{1'b0}}};
      vec_nxt.y = {{(crb_pkg::XW - 33 - crb_pkg::GUARD_BITS){ndx[32]}}, ndx,
                   {crb_pkg::GUARD_BITS{1'b0}}};
      vec_nxt.z = crb_pkg::DEG180;
    end else begin
      vec_nxt.x = {{(crb_pkg::XW - 33 - crb_pkg::GUARD_BITS){dy[32]}}, dy,
                   {crb_pkg::GUARD_BITS{1'b0}}};
      vec_nxt.y = {{(crb_pkg::XW - 33 - crb_pkg::GUARD_BITS){dx[32]}}, dx,
                   {crb_pkg::GUARD_BITS{1'b0}}};
      vec_nxt.z = '0;
    end
  end

  assign free_up = !valid_r || free_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free_up) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free_up && in_valid) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// ----- design/crb_cell.sv -----
module crb_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  crb_pkg::vec_t in_vec,
  input  logic          free_dn,
  output logic          out_valid,
  output crb_pkg::vec_t out_vec,
  output logic          free_up
);

  localparam logic signed [crb_pkg::ZW-1:0] ANG =
    {{(crb_pkg::ZW - 30){1'b0}}, crb_pkg::atan_q24(STAGE[4:0])};

  logic signed [crb_pkg::XW-1:0] xs;
  logic signed [crb_pkg::XW-1:0] ys;
  crb_pkg::vec_t                 vec_nxt;
  crb_pkg::vec_t                 vec_r;
  logic                          valid_r;

  // one micro-rotation, driving y towards zero
  always_comb begin
    xs = in_vec.x >>> STAGE;
    ys = in_vec.y >>> STAGE;
    vec_nxt.same = in_vec.same;
    if (!in_vec.y[crb_pkg::XW-1]) begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + ANG;
    end else begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - ANG;
    end
  end

  assign free_up = !valid_r || free_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free_up) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free_up && in_valid) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// ----- design/crb_post.sv -----
module crb_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  crb_pkg::vec_t      in_vec,
  output logic               free_up,
  output logic               out_valid,
  output crb_pkg::out_word_t out_word,
  input  logic               out_stall
);

  localparam int unsigned UXW = crb_pkg::XW - 1;
  localparam int unsigned UHW = UXW - 32;
  localparam int unsigned HIW = UHW + 33;

  // stage 1: low partial product, angle wrap
  logic [UXW-1:0]           ux;
  logic signed [crb_pkg::ZW-1:0] z_a;
  logic signed [crb_pkg::ZW-1:0] z_b;
  logic [63:0]              pl1_nxt;
  logic [crb_pkg::ZUW-1:0]  zw1_nxt;
  logic                     v1_r;
  logic [UHW-1:0]           uh1_r;
  logic [63:0]              pl1_r;
  logic [crb_pkg::ZUW-1:0]  zw1_r;
  logic                     same1_r;

  // stage 2: high partial product, heading rounding
  logic [HIW-1:0]           hi2_nxt;
  logic [25:0]              hs;
  logic [24:0]              head2_nxt;
  logic                     v2_r;
  logic [HIW-1:0]           hi2_r;
  logic [24:0]              head2_r;
  logic                     same2_r;

  // stage 3: guard rounding, saturation, output word
  logic [HIW:0]             dsum;
  logic [32:0]              dist_sat;
  crb_pkg::out_word_t       out_nxt;
  crb_pkg::out_word_t       out_r;
  logic                     out_valid_r;

  logic free1;
  logic free2;
  logic free3;

  assign free3   = !out_valid_r || !out_stall;
  assign free2   = !v2_r || free3;
  assign free1   = !v1_r || free2;
  assign free_up = free1;

  always_comb begin
    ux      = in_vec.x[crb_pkg::XW-1] ? '0 : in_vec.x[UXW-1:0];
    pl1_nxt = 64'(ux[31:0]) * 64'(crb_pkg::GAIN_Q32);
    z_a     = in_vec.z[crb_pkg::ZW-1] ? in_vec.z + crb_pkg::DEG360 : in_vec.z;
    z_b     = (z_a >= crb_pkg::DEG360) ? z_a - crb_pkg::DEG360 : z_a;
    zw1_nxt = z_b[crb_pkg::ZW-1] ? '0 : z_b[crb_pkg::ZUW-1:0];
  end

  always_comb begin
    hi2_nxt = HIW'(uh1_r) * HIW'(crb_pkg::GAIN_Q32) + HIW'(pl1_r[63:32]);
    hs      = 26'(({1'b0, zw1_r} + 34'd128) >> 8);
    if (hs >= crb_pkg::HEAD_FULL) begin
      head2_nxt = 25'(hs - crb_pkg::HEAD_FULL);
    end else begin
      head2_nxt = hs[24:0];
    end
  end

  always_comb begin
    dsum = {1'b0, hi2_r} + (HIW + 1)'(1 << (crb_pkg::GUARD_BITS - 1));
    if (dsum[HIW:crb_pkg::GUARD_BITS + 33] != '0) begin
      dist_sat = crb_pkg::DIST_MAX;
    end else begin
      dist_sat = dsum[crb_pkg::GUARD_BITS +: 33];
    end
    if (same2_r) begin
      out_nxt.distance = '0;
      out_nxt.heading  = '0;
    end else begin
      out_nxt.distance = dist_sat;
      out_nxt.heading  = head2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1) begin
        v1_r <= in_valid;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (free3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && in_valid) begin
      uh1_r   <= ux[UXW-1:32];
      pl1_r   <= pl1_nxt;
      zw1_r   <= zw1_nxt;
      same1_r <= in_vec.same;
    end
    if (free2 && v1_r) begin
      hi2_r   <= hi2_nxt;
      head2_r <= head2_nxt;
      same2_r <= same1_r;
    end
    if (free3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
